/* rtl/core/pfi_pkg.sv */
// Shared types and constants for the polyphase FIR interpolator.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package pfi_pkg;

   // Field widths fixed by the request and response formats.
   localparam int SAMPLE_W   = 32;
   localparam int COEFF_W    = 18;
   localparam int PROD_W     = SAMPLE_W + COEFF_W;
   localparam int OUT_W      = 24;
   localparam int NFRAME_W   = 13;
   localparam int IDX_W      = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_FORMAT = 2'd1;

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_COEFF = 2'd0,
      REQ_FRAME = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } ctrl_state_type;

   // Per-tap control that travels beside the store reads.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } issue_type;

endpackage

`default_nettype wire

/* rtl/core/pfi_mem.sv */
// Frame store and coefficient store, each with one write and one registered read port.
// Depends on pfi_pkg for the sample and coefficient widths.
`default_nettype none

module pfi_mem #(
   parameter int FRAMES = 4096,
   parameter int CDEPTH = 2048,
   parameter int FAW    = 12,
   parameter int CAW    = 11
) (
   input  wire logic                                  clock,
   input  wire logic                                  frame_we,
   input  wire logic [FAW-1:0]                        frame_waddr,
   input  wire logic [2*pfi_pkg::SAMPLE_W-1:0]        frame_wdata,
   input  wire logic                                  coeff_we,
   input  wire logic [CAW-1:0]                        coeff_waddr,
   input  wire logic signed [pfi_pkg::COEFF_W-1:0]    coeff_wdata,
   input  wire logic                                  rd_en,
   input  wire logic [FAW-1:0]                        frame_raddr,
   input  wire logic [CAW-1:0]                        coeff_raddr,
   output logic [2*pfi_pkg::SAMPLE_W-1:0]             frame_rdata,
   output logic signed [pfi_pkg::COEFF_W-1:0]         coeff_rdata
);

   logic [2*pfi_pkg::SAMPLE_W-1:0]     frame_mem [FRAMES];
   logic signed [pfi_pkg::COEFF_W-1:0] coeff_mem [CDEPTH];

   // Frame store: right sample in the upper half, left in the lower half.
   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      if (rd_en) begin
         frame_rdata <= frame_mem[frame_raddr];
      end
   end

   // Coefficient store, addressed by phase * TAPS + tap.
   always_ff @(posedge clock) begin
      if (coeff_we) begin
         coeff_mem[coeff_waddr] <= coeff_wdata;
      end
      if (rd_en) begin
         coeff_rdata <= coeff_mem[coeff_raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pfi_mac.sv */
// Stereo multiply-accumulate unit with rounding, saturation and the response register.
// Depends on pfi_pkg for widths and the issue_type struct.
`default_nettype none

module pfi_mac #(
   parameter int TAPS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pfi_pkg::issue_type                    issue,
   input  wire logic                                  sample_format,
   input  wire logic [2*pfi_pkg::SAMPLE_W-1:0]        frame_rdata,
   input  wire logic signed [pfi_pkg::COEFF_W-1:0]    coeff_rdata,
   input  wire logic                                  zero_req,
   output logic                                       rsp_valid,
   output logic signed [pfi_pkg::OUT_W-1:0]           rsp_out_left,
   output logic signed [pfi_pkg::OUT_W-1:0]           rsp_out_right
);

   localparam int SW    = pfi_pkg::SAMPLE_W;
   localparam int PW    = pfi_pkg::PROD_W;
   localparam int OW    = pfi_pkg::OUT_W;
   localparam int ACC_W = PW + $clog2(TAPS);

   pfi_pkg::issue_type          rd_ff, mul_ff;
   logic                        accdone_ff, rsp_valid_ff;
   logic signed [SW-1:0]        samp_l, samp_r;
   logic signed [PW-1:0]        prod_l_in, prod_r_in, prod_l_ff, prod_r_ff;
   logic signed [ACC_W-1:0]     acc_l_in, acc_r_in, acc_l_ff, acc_r_ff;
   logic signed [OW-1:0]        out_l_ff, out_r_ff;

   // Stored sample to Q1.31: 16-bit samples sit in the low half and are scaled up.
   function automatic logic signed [SW-1:0] to_q31(input logic [SW-1:0] raw,
                                                  input logic fmt24);
      if (fmt24) begin
         return raw;
      end
      return {raw[15:0], 16'h0000};
   endfunction

   // Round half up from Q3.47 to Q1.23, then clamp to the 24-bit range.
   function automatic logic signed [OW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0] biased;
      logic signed [ACC_W:0] shifted;
      biased  = $signed({acc[ACC_W-1], acc}) + $signed({{(ACC_W-23){1'b0}}, 1'b1, 23'h0});
      shifted = biased >>> 24;
      if (shifted[ACC_W:OW-1] == '0 || shifted[ACC_W:OW-1] == '1) begin
         return shifted[OW-1:0];
      end
      if (shifted[ACC_W]) begin
         return {1'b1, {(OW-1){1'b0}}};
      end
      return {1'b0, {(OW-1){1'b1}}};
   endfunction

   // Multiplier lanes, one per channel, fed straight from the store outputs.
   always_comb begin
      samp_l    = to_q31(frame_rdata[SW-1:0], sample_format);
      samp_r    = to_q31(frame_rdata[2*SW-1:SW], sample_format);
      prod_l_in = samp_l * coeff_rdata;
      prod_r_in = samp_r * coeff_rdata;
   end

   // Accumulators restart on the first tap of a query.
   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (mul_ff.valid) begin
         acc_l_in = (mul_ff.first ? '0 : acc_l_ff) + ACC_W'(prod_l_ff);
         acc_r_in = (mul_ff.first ? '0 : acc_r_ff) + ACC_W'(prod_r_ff);
      end
   end

   // Control pipeline beside the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff        <= '0;
         mul_ff       <= '0;
         accdone_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_ff        <= issue;
         mul_ff       <= rd_ff;
         accdone_ff   <= mul_ff.valid && mul_ff.last;
         rsp_valid_ff <= accdone_ff || zero_req;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      acc_l_ff  <= acc_l_in;
      acc_r_ff  <= acc_r_in;
      priority if (zero_req) begin
         out_l_ff <= '0;
         out_r_ff <= '0;
      end else if (accdone_ff) begin
         out_l_ff <= round_sat(acc_l_ff);
         out_r_ff <= round_sat(acc_r_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;

endmodule

`default_nettype wire

/* rtl/core/pfi_ctrl.sv */
// Query sequencer: walks the tap window, clamps frame indexes and steps coefficient addresses.
// Depends on pfi_pkg for the state enum, request codes and issue_type.
`default_nettype none

module pfi_ctrl #(
   parameter int TAPS   = 32,
   parameter int PHASES = 64,
   parameter int FRAMES = 4096,
   parameter int FAW    = 12,
   parameter int CAW    = 11
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [1:0]                            req_type,
   input  wire logic [15:0]                           position_whole,
   input  wire logic [15:0]                           position_frac,
   input  wire logic [pfi_pkg::NFRAME_W-1:0]          frame_count,
   input  wire logic                                  done,
   output logic                                       busy,
   output logic                                       zero_req,
   output pfi_pkg::issue_type                         issue,
   output logic [FAW-1:0]                             frame_raddr,
   output logic [CAW-1:0]                             coeff_raddr
);

   localparam int IW  = pfi_pkg::IDX_W;
   localparam int NW  = pfi_pkg::NFRAME_W;
   localparam int TCW = $clog2(TAPS);
   localparam logic [TCW-1:0] LAST_TAP = TCW'(TAPS - 1);
   localparam logic [IW-1:0]  WIN_OFS  = IW'(TAPS / 2 - 1);

   pfi_pkg::ctrl_state_type state_ff, state_in;
   logic [TCW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [CAW-1:0] caddr_ff, caddr_in;
   logic [NW-1:0]  nframes, clamped;
   logic           short_store, accept_query;

   // Frame count above the store size acts as the store size.
   always_comb begin
      nframes      = (32'(frame_count) > 32'(FRAMES)) ? NW'(FRAMES) : frame_count;
      short_store  = nframes < NW'(2);
      accept_query = start && (state_ff == pfi_pkg::ST_IDLE) &&
                     (req_type == pfi_pkg::REQ_QUERY);
   end

   // Clamp the running frame index into 0 .. nframes-1.
   always_comb begin
      priority if (idx_ff[IW-1]) begin
         clamped = '0;
      end else if (idx_ff >= IW'(nframes)) begin
         clamped = nframes - NW'(1);
      end else begin
         clamped = NW'(idx_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfi_pkg::ST_IDLE: begin
            if (accept_query && !short_store) begin
               state_in = pfi_pkg::ST_ISSUE;
            end
         end
         pfi_pkg::ST_ISSUE: begin
            if (cnt_ff == LAST_TAP) begin
               state_in = pfi_pkg::ST_WAIT;
            end
         end
         pfi_pkg::ST_WAIT: begin
            if (done) begin
               state_in = pfi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfi_pkg::ST_IDLE;
         end
      endcase
   end

   // Window counters: loaded while idle, stepped once per issued tap.
   always_comb begin
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      caddr_in = caddr_ff;
      if (state_ff == pfi_pkg::ST_IDLE) begin
         cnt_in   = '0;
         idx_in   = IW'(position_whole) - WIN_OFS;
         caddr_in = CAW'(((32'(position_frac) * 32'(PHASES)) >> 16) * 32'(TAPS));
      end else if (state_ff == pfi_pkg::ST_ISSUE) begin
         cnt_in   = cnt_ff + TCW'(1);
         idx_in   = idx_ff + IW'(1);
         caddr_in = caddr_ff + CAW'(1);
      end
   end

   // Outputs.
   always_comb begin
      busy        = (state_ff != pfi_pkg::ST_IDLE);
      zero_req    = accept_query && short_store;
      issue.valid = (state_ff == pfi_pkg::ST_ISSUE);
      issue.first = (cnt_ff == '0);
      issue.last  = (cnt_ff == LAST_TAP);
      frame_raddr = FAW'(clamped);
      coeff_raddr = caddr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      caddr_ff <= caddr_in;
   end

   // Every issued frame read lands inside the valid part of the store.
   a_frame_in_range: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> (32'(frame_raddr) < 32'(nframes)))
      else $error("frame read outside the valid frames");

   // Coefficient addresses walk one row without gaps.
   a_coeff_walk: assert property (@(posedge clock) disable iff (reset)
      issue.valid && !issue.last |=>
         issue.valid && (coeff_raddr == $past(coeff_raddr) + CAW'(1)))
      else $error("coefficient address skipped");

   // A full query starts issuing at its first tap on the next cycle.
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      accept_query && !short_store |=> busy && issue.valid && issue.first)
      else $error("query did not start issuing");

   // Nothing is issued while draining, and the block stays busy until done.
   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfi_pkg::ST_WAIT) && !done |=> busy && !issue.valid)
      else $error("drain left early or issued a tap");

endmodule

`default_nettype wire

/* rtl/core/polyphase_fir_interpolator.sv */
// Top level of the stereo polyphase FIR interpolator.
// Depends on pfi_pkg, pfi_mem, pfi_mac and pfi_ctrl.
//
// Usage:
//   Requests are taken at a rising edge with start high and busy low.
//   req_type selects a coefficient write, a frame write or a query.
//   Writes finish in the accepting cycle; busy stays low.
//   A query reads TAPS taps through one shared stereo multiply-accumulate
//   unit, one tap per cycle, then rounds and saturates to Q1.23.
//   Its response strobes rsp_valid for one cycle after the issue, store read,
//   product, accumulate, done and output registers; busy falls as the response
//   is taken, so the next request waits until then and queries never overlap.
//   With fewer than two valid frames a query answers zero in the next cycle
//   and busy stays low.
//   Registers frame_count (index 0) and sample_format (index 1) are written
//   through csr_valid/csr_ready/csr_index/csr_data; the user must write them only
//   while the block is idle, as the block does not enforce it; csr_ready is always high.
//   Reset clears the registers and the sequencer; the stores keep whatever
//   they hold and must be written before they are read.
//   The receiver cannot stall: each response is valid for exactly one cycle.
`default_nettype none

module polyphase_fir_interpolator #(
   parameter int TAPS   = 32,
   parameter int PHASES = 64,
   parameter int FRAMES = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [1:0]                            req_type,
   input  wire logic [5:0]                            req_coeff_phase,
   input  wire logic [4:0]                            req_coeff_tap,
   input  wire logic signed [pfi_pkg::COEFF_W-1:0]    req_coeff_value,
   input  wire logic [11:0]                           req_frame_index,
   input  wire logic signed [pfi_pkg::SAMPLE_W-1:0]   req_sample_left,
   input  wire logic signed [pfi_pkg::SAMPLE_W-1:0]   req_sample_right,
   input  wire logic [15:0]                           req_position_whole,
   input  wire logic [15:0]                           req_position_frac,
   output logic                                       rsp_valid,
   output logic signed [pfi_pkg::OUT_W-1:0]           rsp_out_left,
   output logic signed [pfi_pkg::OUT_W-1:0]           rsp_out_right,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pfi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [pfi_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int FAW    = $clog2(FRAMES);
   localparam int CDEPTH = PHASES * TAPS;
   localparam int CAW    = $clog2(CDEPTH);
   localparam int NW     = pfi_pkg::NFRAME_W;

   logic [NW-1:0]               frame_count_ff;
   logic                        sample_format_ff;
   logic                        accept, frame_we, coeff_we, zero_req;
   logic [CAW-1:0]              coeff_waddr;
   logic [FAW-1:0]              frame_raddr;
   logic [CAW-1:0]              coeff_raddr;
   logic [2*pfi_pkg::SAMPLE_W-1:0]     frame_rdata;
   logic signed [pfi_pkg::COEFF_W-1:0] coeff_rdata;
   pfi_pkg::issue_type          issue;

   // Write requests go to the stores in the accepting cycle; out-of-range slots are dropped.
   always_comb begin
      accept      = start && !busy;
      frame_we    = accept && (req_type == pfi_pkg::REQ_FRAME) &&
                    (32'(req_frame_index) < 32'(FRAMES));
      coeff_we    = accept && (req_type == pfi_pkg::REQ_COEFF) &&
                    (32'(req_coeff_phase) < 32'(PHASES)) &&
                    (32'(req_coeff_tap) < 32'(TAPS));
      coeff_waddr = CAW'(32'(req_coeff_phase) * 32'(TAPS) + 32'(req_coeff_tap));
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff   <= '0;
         sample_format_ff <= 1'b0;
      end else if (csr_valid) begin
         priority if (csr_index == pfi_pkg::CSR_FRAME_COUNT) begin
            frame_count_ff <= csr_data[NW-1:0];
         end else if (csr_index == pfi_pkg::CSR_SAMPLE_FORMAT) begin
            sample_format_ff <= csr_data[0];
         end
      end
   end

   pfi_ctrl #(
      .TAPS   (TAPS),
      .PHASES (PHASES),
      .FRAMES (FRAMES),
      .FAW    (FAW),
      .CAW    (CAW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_type       (req_type),
      .position_whole (req_position_whole),
      .position_frac  (req_position_frac),
      .frame_count    (frame_count_ff),
      .done           (rsp_valid),
      .busy           (busy),
      .zero_req       (zero_req),
      .issue          (issue),
      .frame_raddr    (frame_raddr),
      .coeff_raddr    (coeff_raddr)
   );

   pfi_mem #(
      .FRAMES (FRAMES),
      .CDEPTH (CDEPTH),
      .FAW    (FAW),
      .CAW    (CAW)
   ) u_mem (
      .clock       (clock),
      .frame_we    (frame_we),
      .frame_waddr (FAW'(req_frame_index)),
      .frame_wdata ({req_sample_right, req_sample_left}),
      .coeff_we    (coeff_we),
      .coeff_waddr (coeff_waddr),
      .coeff_wdata (req_coeff_value),
      .rd_en       (issue.valid),
      .frame_raddr (frame_raddr),
      .coeff_raddr (coeff_raddr),
      .frame_rdata (frame_rdata),
      .coeff_rdata (coeff_rdata)
   );

   pfi_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .issue         (issue),
      .sample_format (sample_format_ff),
      .frame_rdata   (frame_rdata),
      .coeff_rdata   (coeff_rdata),
      .zero_req      (zero_req),
      .rsp_valid     (rsp_valid),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right)
   );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking testbench for polyphase_fir_interpolator: directed and random requests,
// with every response compared against a behavioral model of the stereo FIR sum.
// Depends on pfi_pkg and the RTL under rtl/core.
module tb_top;

   localparam int TAPS          = 32;
   localparam int PHASES        = 64;
   localparam int FRAMES        = 4096;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = TAPS + 8;
   localparam int DRAIN_LIMIT   = 4 * (TAPS + 4) + 100;
   localparam int TIMEOUT_NS    = 10_000_000;
   localparam int PHASE_SHIFT   = 16 - $clog2(PHASES);

   localparam int SAMPLE_W   = pfi_pkg::SAMPLE_W;
   localparam int COEFF_W    = pfi_pkg::COEFF_W;
   localparam int OUT_W      = pfi_pkg::OUT_W;
   localparam int NFRAME_W   = pfi_pkg::NFRAME_W;
   localparam int CSR_IDX_W  = pfi_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = pfi_pkg::CSR_DATA_W;

   // Index 3 has no register behind it; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam longint Q23_MAX = 64'sd8388607;
   localparam longint Q23_MIN = -64'sd8388608;
   localparam logic signed [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
   localparam logic signed [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

   typedef struct {
      pfi_pkg::req_code_type       kind;
      logic [5:0]                  phase;
      logic [4:0]                  tap;
      logic signed [COEFF_W-1:0]   coeff;
      logic [11:0]                 frame;
      logic [SAMPLE_W-1:0]         left;
      logic [SAMPLE_W-1:0]         right;
      logic [15:0]                 whole;
      logic [15:0]                 frac;
   } pfi_request_type;

   typedef struct {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
   } stereo_sample_type;

   // How store entries are filled when a query window needs them.
   typedef enum {
      FILL_RANDOM,
      FILL_MAX,
      FILL_MIN
   } fill_style_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [1:0]                  req_type = '0;
   logic [5:0]                  req_coeff_phase = '0;
   logic [4:0]                  req_coeff_tap = '0;
   logic signed [COEFF_W-1:0]   req_coeff_value = '0;
   logic [11:0]                 req_frame_index = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_left = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_right = '0;
   logic [15:0]                 req_position_whole = '0;
   logic [15:0]                 req_position_frac = '0;
   logic                        rsp_valid;
   logic signed [OUT_W-1:0]     rsp_out_left;
   logic signed [OUT_W-1:0]     rsp_out_right;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   // Shadow copy of the stores, the registers and the outstanding responses.
   logic [SAMPLE_W-1:0]         shadow_left[FRAMES];
   logic [SAMPLE_W-1:0]         shadow_right[FRAMES];
   logic signed [COEFF_W-1:0]   shadow_coeff[PHASES*TAPS];
   bit                          frame_loaded[FRAMES];
   bit                          coeff_loaded[PHASES*TAPS];
   logic [NFRAME_W-1:0]         frame_count_reg = '0;
   logic                        sample_format_reg = 1'b0;
   stereo_sample_type           expected_stereo[$];
   int                          error_count = 0;
   int                          sent_count = 0;
   int                          sender_idle_pct = 0;
   fill_style_type              fill_style = FILL_RANDOM;

   always #(HALF_PERIOD) clock = ~clock;

   polyphase_fir_interpolator #(
      .TAPS   (TAPS),
      .PHASES (PHASES),
      .FRAMES (FRAMES)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_coeff_phase    (req_coeff_phase),
      .req_coeff_tap      (req_coeff_tap),
      .req_coeff_value    (req_coeff_value),
      .req_frame_index    (req_frame_index),
      .req_sample_left    (req_sample_left),
      .req_sample_right   (req_sample_right),
      .req_position_whole (req_position_whole),
      .req_position_frac  (req_position_frac),
      .rsp_valid          (rsp_valid),
      .rsp_out_left       (rsp_out_left),
      .rsp_out_right      (rsp_out_right),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // A frame_count above the store size behaves as the store size.
   function automatic int active_frames();
      return (frame_count_reg > FRAMES) ? FRAMES : int'(frame_count_reg);
   endfunction

   function automatic int phase_of(logic [15:0] frac);
      return (int'(frac) * PHASES) >> 16;
   endfunction

   // Frame read by tap t, clamped to the valid part of the store.
   function automatic int window_frame(logic [15:0] whole, int t, int nframes);
      int idx;
      idx = int'(whole) - TAPS / 2 + 1 + t;
      if (idx < 0) idx = 0;
      if (idx >= nframes) idx = nframes - 1;
      return idx;
   endfunction

   // Stored samples become Q1.31; 16-bit samples live in the low half, scaled up.
   function automatic longint sample_as_q31(logic [SAMPLE_W-1:0] raw);
      if (sample_format_reg) return longint'($signed(raw));
      return longint'($signed(raw[15:0])) * 64'sd65536;
   endfunction

   // Round half up from Q3.47 to Q1.23, then saturate.
   function automatic logic signed [OUT_W-1:0] round_to_q23(longint acc);
      longint r;
      r = (acc + 64'sd8388608) >>> 24;
      if (r > Q23_MAX) r = Q23_MAX;
      if (r < Q23_MIN) r = Q23_MIN;
      return r[OUT_W-1:0];
   endfunction

   // Expected stereo output of one query against the current shadow state.
   function automatic stereo_sample_type interpolate_stereo(logic [15:0] whole,
                                                            logic [15:0] frac);
      stereo_sample_type res;
      longint acc_l;
      longint acc_r;
      longint c;
      int nframes;
      int ph;
      int idx;
      acc_l = 0;
      acc_r = 0;
      nframes = active_frames();
      if (nframes < 2) begin
         res.left = '0;
         res.right = '0;
         return res;
      end
      ph = phase_of(frac);
      for (int t = 0; t < TAPS; t++) begin
         idx = window_frame(whole, t, nframes);
         c = longint'(shadow_coeff[ph*TAPS + t]);
         acc_l += sample_as_q31(shadow_left[idx]) * c;
         acc_r += sample_as_q31(shadow_right[idx]) * c;
      end
      res.left = round_to_q23(acc_l);
      res.right = round_to_q23(acc_r);
      return res;
   endfunction

   // Coefficients of widely spread magnitude so that sums both saturate and stay in range.
   function automatic logic signed [COEFF_W-1:0] random_coeff();
      logic signed [COEFF_W-1:0] v;
      if (fill_style == FILL_MAX) return COEFF_MAX;
      if (fill_style == FILL_MIN) return COEFF_MIN;
      v = COEFF_W'($urandom);
      return v >>> $urandom_range(0, 9);
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] v;
      if (fill_style == FILL_MAX) return sample_format_reg ? 32'h7FFF_FFFF : 32'h0000_7FFF;
      if (fill_style == FILL_MIN) return sample_format_reg ? 32'h8000_0000 : 32'hFFFF_8000;
      v = $urandom;
      if (sample_format_reg) v = $signed(v) >>> $urandom_range(0, 16);
      else v[15:0] = $signed(v[15:0]) >>> $urandom_range(0, 8);
      return v;
   endfunction

   // Fields that the request code does not use carry random values.
   function automatic pfi_request_type blank_request(pfi_pkg::req_code_type kind);
      pfi_request_type rq;
      rq.kind = kind;
      rq.phase = 6'($urandom);
      rq.tap = 5'($urandom);
      rq.coeff = COEFF_W'($urandom);
      rq.frame = 12'($urandom);
      rq.left = $urandom;
      rq.right = $urandom;
      rq.whole = 16'($urandom);
      rq.frac = 16'($urandom);
      return rq;
   endfunction

   // Send one request, wait for it to be taken, then update the shadow state.
   // Start stays high on return so that a following request can go back to back.
   task automatic send_request(input pfi_request_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_type           <= rq.kind;
      req_coeff_phase    <= rq.phase;
      req_coeff_tap      <= rq.tap;
      req_coeff_value    <= rq.coeff;
      req_frame_index    <= rq.frame;
      req_sample_left    <= rq.left;
      req_sample_right   <= rq.right;
      req_position_whole <= rq.whole;
      req_position_frac  <= rq.frac;
      do @(posedge clock); while (busy);
      sent_count++;
      case (rq.kind)
         pfi_pkg::REQ_COEFF: begin
            shadow_coeff[rq.phase*TAPS + rq.tap] = rq.coeff;
            coeff_loaded[rq.phase*TAPS + rq.tap] = 1'b1;
         end
         pfi_pkg::REQ_FRAME: begin
            shadow_left[rq.frame] = rq.left;
            shadow_right[rq.frame] = rq.right;
            frame_loaded[rq.frame] = 1'b1;
         end
         pfi_pkg::REQ_QUERY: expected_stereo.push_back(interpolate_stereo(rq.whole, rq.frac));
         default: ;
      endcase
   endtask

   task automatic send_coeff(input int ph, input int tap, input logic signed [COEFF_W-1:0] v);
      pfi_request_type rq;
      rq = blank_request(pfi_pkg::REQ_COEFF);
      rq.phase = 6'(ph);
      rq.tap = 5'(tap);
      rq.coeff = v;
      send_request(rq);
   endtask

   task automatic send_frame(input int idx, input logic [SAMPLE_W-1:0] l,
                             input logic [SAMPLE_W-1:0] r);
      pfi_request_type rq;
      rq = blank_request(pfi_pkg::REQ_FRAME);
      rq.frame = 12'(idx);
      rq.left = l;
      rq.right = r;
      send_request(rq);
   endtask

   // Load every store entry the query will read that has never been written, then query.
   task automatic send_query(input logic [15:0] whole, input logic [15:0] frac);
      pfi_request_type rq;
      int nframes;
      int ph;
      int idx;
      nframes = active_frames();
      if (nframes >= 2) begin
         ph = phase_of(frac);
         for (int t = 0; t < TAPS; t++) begin
            if (!coeff_loaded[ph*TAPS + t]) send_coeff(ph, t, random_coeff());
         end
         for (int t = 0; t < TAPS; t++) begin
            idx = window_frame(whole, t, nframes);
            if (!frame_loaded[idx]) send_frame(idx, random_sample(), random_sample());
         end
      end
      rq = blank_request(pfi_pkg::REQ_QUERY);
      rq.whole = whole;
      rq.frac = frac;
      send_request(rq);
   endtask

   // Hold off new requests until every response is in and the block has settled.
   task automatic wait_idle();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_stereo.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_stereo.size() != 0) begin
         $error("%0d expected responses never arrived", expected_stereo.size());
         error_count++;
         expected_stereo.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      start     <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pfi_pkg::CSR_FRAME_COUNT:   frame_count_reg = data[NFRAME_W-1:0];
         pfi_pkg::CSR_SAMPLE_FORMAT: sample_format_reg = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Only the low bit of the format data matters; the rest is random.
   task automatic configure(input logic [CSR_DATA_W-1:0] count_data, input logic fmt);
      logic [CSR_DATA_W-1:0] fmt_data;
      fmt_data = CSR_DATA_W'($urandom);
      fmt_data[0] = fmt;
      wait_idle();
      write_csr(pfi_pkg::CSR_FRAME_COUNT, count_data);
      write_csr(pfi_pkg::CSR_SAMPLE_FORMAT, fmt_data);
   endtask

   // Fewer than two frames: queries answer zero and read nothing.
   task automatic test_short_store();
      // Bits above the 13-bit count are dropped, so this leaves zero frames.
      configure(16'hE000, 1'b0);
      send_query(16'h0000, 16'h0000);
      send_query(16'hFFFF, 16'hFFFF);
      send_request(blank_request(pfi_pkg::REQ_NONE));
      wait_idle();
      write_csr(CSR_UNUSED, 16'hFFFF);
      configure(16'd1, 1'b1);
      send_query(16'd1, 16'h8000);
      send_request(blank_request(pfi_pkg::REQ_NONE));
      send_query(16'h0000, 16'h0000);
   endtask

   // Full-scale samples and coefficients in both sample formats, to hit saturation.
   task automatic test_extreme_values();
      configure(16'd2, 1'b1);
      fill_style = FILL_MAX;
      send_query(16'd0, 16'hFFFF);
      fill_style = FILL_RANDOM;
      send_frame(0, 32'h8000_0000, 32'h8000_0000);
      send_frame(1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_query(16'd1, 16'hFFFF);
      send_coeff(PHASES - 1, 0, COEFF_MIN);
      send_query(16'd0, 16'hFC00);
      configure(16'd2, 1'b0);
      send_query(16'd0, 16'hFFFF);
      send_frame(0, 32'h0000_8000, 32'hFFFF_7FFF);
      send_query(16'd1, 16'hFFFF);
   endtask

   // Windows that run off both ends of the store, and a count above the store size.
   task automatic test_window_clamping();
      configure(CSR_DATA_W'(FRAMES), 1'b1);
      send_query(16'd0, 16'h0000);
      send_query(16'hFFFF, 16'h03FF);
      send_query(16'(FRAMES / 2), 16'h8000);
      send_query(16'(FRAMES - 1), 16'h0400);
      configure(16'h1FFF, 1'b0);
      send_query(16'(FRAMES + 4), 16'hFFFF);
      send_query(16'(FRAMES - TAPS / 2), 16'h0000);
   endtask

   // One random phase: queries, the largest share, around a small stretch of frames and a pair
   // of phases, plus writes and unused codes. The loads a query needs count toward n_items.
   task automatic run_random_phase(input int n_items, input int idle_pct,
                                   input logic [CSR_DATA_W-1:0] count_data, input logic fmt);
      int pick;
      int nframes;
      int idx;
      int stop_at;
      int drain_at;
      int phase_base;
      int whole_base;
      logic [15:0] whole;
      logic [15:0] frac;
      configure(count_data, fmt);
      sender_idle_pct = idle_pct;
      nframes = active_frames();
      stop_at = sent_count + n_items;
      drain_at = sent_count + n_items / 2;
      phase_base = $urandom_range(0, PHASES - 2);
      whole_base = $urandom_range(0, (nframes > TAPS) ? nframes - TAPS : 0);
      while (sent_count < stop_at) begin
         // Halfway through, and now and then, let every response drain first.
         if (sent_count >= drain_at) begin
            wait_idle();
            drain_at = stop_at;
         end else if ($urandom_range(99) < 2) begin
            wait_idle();
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            case ($urandom_range(9))
               0:       whole = 16'h0000;
               1:       whole = 16'hFFFF;
               2:       whole = 16'($urandom);
               default: whole = 16'(whole_base + $urandom_range(0, 7));
            endcase
            frac = 16'(((phase_base + $urandom_range(0, 1)) << PHASE_SHIFT) |
                       $urandom_range(0, (1 << PHASE_SHIFT) - 1));
            send_query(whole, frac);
         end else if (pick < 70) begin
            send_coeff($urandom_range(0, PHASES - 1), $urandom_range(0, TAPS - 1),
                       random_coeff());
         end else if (pick < 95) begin
            idx = (nframes > 0 && $urandom_range(3) != 0) ?
                  $urandom_range(0, nframes - 1) : $urandom_range(0, FRAMES - 1);
            send_frame(idx, random_sample(), random_sample());
         end else begin
            send_request(blank_request(pfi_pkg::REQ_NONE));
         end
      end
      sender_idle_pct = 0;
   endtask

   // The receiver cannot stall, so only the sender idles in these phases.
   task automatic test_random_traffic();
      run_random_phase(160, 0, CSR_DATA_W'(FRAMES), 1'b1);
      run_random_phase(160, 85, CSR_DATA_W'($urandom_range(2, 300)), 1'b0);
      run_random_phase(160, 37, 16'h1FFF, 1'b1);
      run_random_phase(60, 85, 16'd1, 1'b0);
      run_random_phase(180, 37, CSR_DATA_W'($urandom_range(2, FRAMES)),
                       1'($urandom_range(0, 1)));
   endtask

   // Compare each response with the oldest outstanding expectation.
   always @(posedge clock) begin : check_responses
      stereo_sample_type want;
      if (!reset && rsp_valid) begin
         if (expected_stereo.size() == 0) begin
            $error("response with no query outstanding: out_left %0d, out_right %0d",
                   rsp_out_left, rsp_out_right);
            error_count++;
         end else begin
            want = expected_stereo.pop_front();
            if (rsp_out_left !== want.left) begin
               $error("out_left mismatch: expected %0d, actual %0d", want.left, rsp_out_left);
               error_count++;
            end
            if (rsp_out_right !== want.right) begin
               $error("out_right mismatch: expected %0d, actual %0d",
                      want.right, rsp_out_right);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_store();
      test_extreme_values();
      test_window_clamping();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
